@@ design/esh_pkg.sv @@
// shared constants, types and helpers for the event spectra histogrammer
package esh_pkg;

  localparam int unsigned CHANNELS    = 384;
  localparam int unsigned ENERGY_BINS = 4096;
  localparam int unsigned TIME_BINS   = 1024;
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned CH_W    = 9;
  localparam int unsigned EBIN_W  = 12;
  localparam int unsigned TBIN_W  = 10;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned EADDR_W = CH_W + EBIN_W;
  localparam int unsigned TADDR_W = CH_W + TBIN_W;
  localparam int unsigned E_DEPTH = CHANNELS * ENERGY_BINS;
  localparam int unsigned T_DEPTH = CHANNELS * TIME_BINS;

  // event word layout
  localparam int unsigned TS_BIT    = 31;
  localparam int unsigned CH_LSB    = 22;
  localparam int unsigned TIME_LSB  = 12;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [EADDR_W-1:0]     eaddr_t;
  typedef logic [TADDR_W-1:0]     taddr_t;

  typedef enum logic [1:0] {
    ACT_EVENT     = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_RD_ENERGY = 2'd2,
    ACT_RD_TIME   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_RD,
    ST_EV_WR,
    ST_RD_MEM,
    ST_RD_RESP
  } state_e;

  typedef struct packed {
    logic latch;        // capture request addresses
    logic count_event;  // bump the event total
    logic sweep_start;  // restart the clear sweep and zero the total
    logic sweep_en;     // write zeros at the sweep address
    logic mem_wr;       // write back incremented bin counts
    logic out_load;     // load the result register
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } status_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] c);
    return (c >= CH_W'(CHANNELS)) ? CH_W'(CHANNELS - 1) : c;
  endfunction

  function automatic logic [EBIN_W-1:0] clamp_ebin(input logic [EBIN_W-1:0] b);
    return ({1'b0, b} >= (EBIN_W + 1)'(ENERGY_BINS)) ? EBIN_W'(ENERGY_BINS - 1) : b;
  endfunction

  function automatic logic [TBIN_W-1:0] clamp_tbin(input logic [EBIN_W-1:0] b);
    return (b >= EBIN_W'(TIME_BINS)) ? TBIN_W'(TIME_BINS - 1) : b[TBIN_W-1:0];
  endfunction

endpackage

@@ design/esh_ctrl.sv @@
// controller state machine: sequences events, reads and the clear sweep
module esh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic              ts_flag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  esh_pkg::status_t  status_i,
  output esh_pkg::cmd_t     cmd_o
);

  esh_pkg::state_e  state_q, state_d;
  esh_pkg::action_e act;
  logic             accept;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign act      = esh_pkg::action_e'(action_i);
  assign accept   = in_valid_i && (state_q == esh_pkg::ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      esh_pkg::ST_CLEAR: begin
        if (status_i.sweep_last) state_d = esh_pkg::ST_IDLE;
      end
      esh_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (act) inside
            esh_pkg::ACT_EVENT:     state_d = ts_flag_i ? esh_pkg::ST_IDLE : esh_pkg::ST_EV_RD;
            esh_pkg::ACT_CLEAR:     state_d = esh_pkg::ST_CLEAR;
            esh_pkg::ACT_RD_ENERGY,
            esh_pkg::ACT_RD_TIME:   state_d = esh_pkg::ST_RD_MEM;
            default:                state_d = esh_pkg::ST_IDLE;
          endcase
        end
      end
      esh_pkg::ST_EV_RD:   state_d = esh_pkg::ST_EV_WR;
      esh_pkg::ST_EV_WR:   state_d = esh_pkg::ST_IDLE;
      esh_pkg::ST_RD_MEM:  state_d = esh_pkg::ST_RD_RESP;
      esh_pkg::ST_RD_RESP: begin
        if (out_free) state_d = esh_pkg::ST_IDLE;
      end
      default:             state_d = esh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.latch       = accept;
    cmd_o.count_event = accept && (act == esh_pkg::ACT_EVENT) && !ts_flag_i;
    cmd_o.sweep_start = accept && (act == esh_pkg::ACT_CLEAR);
    cmd_o.sweep_en    = (state_q == esh_pkg::ST_CLEAR);
    cmd_o.mem_wr      = (state_q == esh_pkg::ST_EV_WR);
    cmd_o.out_load    = (state_q == esh_pkg::ST_RD_RESP) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esh_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == esh_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/esh_datapath.sv @@
// datapath: bin memories, clear sweep counter, event total and result register
module esh_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  esh_pkg::cmd_t                       cmd_i,
  output esh_pkg::status_t                    status_o,
  input  logic [1:0]                          action_i,
  input  logic [esh_pkg::WORD_W-1:0]          event_word_i,
  input  logic [esh_pkg::CH_W-1:0]            channel_i,
  input  logic [esh_pkg::EBIN_W-1:0]          bin_i,
  output logic [31:0]                         bin_count_o,
  output logic [31:0]                         event_total_o
);

  esh_pkg::count_t energy_mem [esh_pkg::E_DEPTH];
  esh_pkg::count_t time_mem   [esh_pkg::T_DEPTH];

  esh_pkg::eaddr_t  sweep_q, sweep_d;
  esh_pkg::eaddr_t  ea_q, ea_d, e_addr;
  esh_pkg::taddr_t  ta_q, ta_d, t_addr;
  logic             sel_time_q;
  esh_pkg::count_t  e_rd_q, t_rd_q, e_wdata, t_wdata;
  logic             e_we, t_we;
  esh_pkg::count_t  total_q, total_d;
  logic [31:0]      bin_count_q, event_total_q;

  logic [esh_pkg::CH_W-1:0]   ev_ch, rd_ch;
  logic [esh_pkg::TBIN_W-1:0] ev_tb;
  logic [esh_pkg::EBIN_W-1:0] ev_eb;
  esh_pkg::action_e           act;

  assign act   = esh_pkg::action_e'(action_i);
  assign ev_ch = esh_pkg::clamp_ch(event_word_i[esh_pkg::CH_LSB +: esh_pkg::CH_W]);
  assign ev_tb = event_word_i[esh_pkg::TIME_LSB +: esh_pkg::TBIN_W];
  assign ev_eb = esh_pkg::clamp_ebin(event_word_i[esh_pkg::EBIN_W-1:0]);
  assign rd_ch = esh_pkg::clamp_ch(channel_i);

  always_comb begin
    if (act == esh_pkg::ACT_EVENT) begin
      ea_d = {ev_ch, ev_eb};
      ta_d = {ev_ch, ev_tb};
    end else begin
      ea_d = {rd_ch, esh_pkg::clamp_ebin(bin_i)};
      ta_d = {rd_ch, esh_pkg::clamp_tbin(bin_i)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ea_q       <= ea_d;
      ta_q       <= ta_d;
      sel_time_q <= (act == esh_pkg::ACT_RD_TIME);
    end
  end

  // clear sweep walks the energy store; the smaller time store rides along
  always_comb begin
    sweep_d = sweep_q;
    if (cmd_i.sweep_start) sweep_d = '0;
    else if (cmd_i.sweep_en) sweep_d = sweep_q + esh_pkg::EADDR_W'(1);
  end

  assign status_o.sweep_last = (sweep_q == esh_pkg::EADDR_W'(esh_pkg::E_DEPTH - 1));

  always_comb begin
    total_d = total_q;
    if (cmd_i.sweep_start) total_d = '0;
    else if (cmd_i.count_event) total_d = total_q + esh_pkg::COUNT_WIDTH'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      total_q <= '0;
    end else begin
      sweep_q <= sweep_d;
      total_q <= total_d;
    end
  end

  assign e_addr  = cmd_i.sweep_en ? sweep_q : ea_q;
  assign t_addr  = cmd_i.sweep_en ? sweep_q[esh_pkg::TADDR_W-1:0] : ta_q;
  assign e_we    = cmd_i.sweep_en || cmd_i.mem_wr;
  assign t_we    = (cmd_i.sweep_en && (sweep_q < esh_pkg::EADDR_W'(esh_pkg::T_DEPTH)))
                   || cmd_i.mem_wr;
  assign e_wdata = cmd_i.sweep_en ? '0 : e_rd_q + esh_pkg::COUNT_WIDTH'(1);
  assign t_wdata = cmd_i.sweep_en ? '0 : t_rd_q + esh_pkg::COUNT_WIDTH'(1);

  always_ff @(posedge clk_i) begin
    if (e_we) energy_mem[e_addr] <= e_wdata;
    e_rd_q <= energy_mem[e_addr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) time_mem[t_addr] <= t_wdata;
    t_rd_q <= time_mem[t_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_count_q   <= sel_time_q ? t_rd_q[31:0] : e_rd_q[31:0];
      event_total_q <= total_q[31:0];
    end
  end

  assign bin_count_o   = bin_count_q;
  assign event_total_o = event_total_q;

endmodule

@@ design/event_spectra_histogrammer.sv @@
// top level: per-channel energy and time spectrum histogrammer
// an event word: accept, memory read, write back; a timestamp word is only accepted
// a bin read: accept, registered memory read, result load once the output is free
// clear walks all 1572864 energy entries (time entries alongside), one per cycle
// after reset the same clearing pass runs to completion before a request is taken
// rst_ni is asynchronous active low and clears the controller, sweep counter and total
module event_spectra_histogrammer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] event_word_i,
  input  logic [8:0]  channel_i,
  input  logic [11:0] bin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] bin_count_o,
  output logic [31:0] event_total_o
);

  esh_pkg::cmd_t    cmd;
  esh_pkg::status_t status;

  esh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .ts_flag_i   (event_word_i[esh_pkg::TS_BIT]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  esh_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (action_i),
    .event_word_i  (event_word_i),
    .channel_i     (channel_i),
    .bin_i         (bin_i),
    .bin_count_o   (bin_count_o),
    .event_total_o (event_total_o)
  );

  // no request taken while the clear sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep_en |-> !in_ready_o)
    else $error("request accepted during clear sweep");

  // sweep writes and bin write-backs never collide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.sweep_en && cmd.mem_wr))
    else $error("sweep and write-back in the same cycle");

  // an accepted event word is written back after its memory read state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == esh_pkg::ACT_EVENT && !event_word_i[31])
      |-> ##2 cmd.mem_wr)
    else $error("event write-back missing");

  // an accepted clear starts the sweep next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == esh_pkg::ACT_CLEAR) |=> cmd.sweep_en)
    else $error("clear did not start the sweep");

endmodule
